@@ hdl/avsmf_pkg.sv @@
package avsmf_pkg;

    localparam int SAMPLE_W      = 12;
    localparam int ACC_W         = 20;
    localparam int READING_W     = 9;
    localparam int COUNT_W       = 4;
    localparam int S_TDATA_W     = 16;
    localparam int M_TDATA_W     = 16;

    // reading = (sum / SAMPLES_PER_READING) >> READING_SHIFT
    localparam int READING_SHIFT  = 3;
    // median is the element at index count / MEDIAN_DIVISOR
    localparam int MEDIAN_DIVISOR = 2;

    localparam int SAMPLES_PER_READING_DEF = 8;
    localparam int WINDOW_LENGTH_DEF       = 11;

endpackage

@@ hdl/averaged_sliding_median_filter_unit.sv @@
// Channel   Dir  tdata fields (low bit up)                      Use
// s_axis    in   adc_sample[11:0], zero pad [15:12]             raw converter samples
// m_axis    out  median_value[8:0], readings_held[12:9], pad    one median per group
//
// A sample that does not close a group only adds to the group sum. A closing sample runs
// these steps: one that scales the group sum by a constant reciprocal, one ring write, then
// nine passes over the ring memory (one read per cycle, each pass reading all readings held,
// at most WINDOW_LENGTH) that settle the median one bit at a time, and a load of the output.
// rst_n is asynchronous; the ring memory is not cleared (only written slots are read).
// Samples are taken while a result waits on m_axis; a new result stalls until it leaves.
module averaged_sliding_median_filter_unit #(
    parameter int SAMPLES_PER_READING = avsmf_pkg::SAMPLES_PER_READING_DEF,
    parameter int WINDOW_LENGTH       = avsmf_pkg::WINDOW_LENGTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // adc_sample[11:0], zeros [15:12]
    input  logic [avsmf_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // median_value[8:0], readings_held[12:9], zeros [15:13]
    output logic [avsmf_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
    import avsmf_pkg::*;

    localparam int GRP_W   = (SAMPLES_PER_READING > 1) ? $clog2(SAMPLES_PER_READING) : 1;
    localparam int SLOT_W  = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
    localparam int DIVISOR = SAMPLES_PER_READING << READING_SHIFT;
    // floor(sum / DIVISOR) == (sum * ceil(2^(ACC_W+l) / DIVISOR)) >> (ACC_W+l), l = clog2
    localparam int DIV_SH   = $clog2(DIVISOR);
    localparam int RECIP_SH = ACC_W + DIV_SH;
    localparam int RECIP_W  = ACC_W + 1;
    localparam int PROD_W   = ACC_W + RECIP_W;
    localparam logic [63:0] RECIP_WIDE =
        ((64'd1 << RECIP_SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_WIDE);
    localparam logic [COUNT_W-1:0] WIN_CNT = COUNT_W'(WINDOW_LENGTH);
    localparam logic [READING_W-1:0] MSB_MASK = {1'b1, {(READING_W-1){1'b0}}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_WRITE,
        ST_SCAN,
        ST_TALLY,
        ST_DONE
    } state_t;

    state_t                 state_reg;
    logic [ACC_W-1:0]       acc_reg;
    logic [GRP_W-1:0]       grp_cnt_reg;
    logic [READING_W-1:0]   quo_reg;
    logic [SLOT_W-1:0]      slot_reg;
    logic [COUNT_W-1:0]     fill_reg;
    logic [SLOT_W-1:0]      scan_idx_reg;
    logic [READING_W-1:0]   bit_mask_reg;
    logic [READING_W-1:0]   res_reg;
    logic [COUNT_W-1:0]     le_cnt_reg;
    logic                   rd_valid_reg;
    logic [READING_W-1:0]   rd_data_reg;
    logic                   m_valid_reg;
    logic [READING_W-1:0]   median_reg;
    logic [COUNT_W-1:0]     held_reg;

    logic [READING_W-1:0]   ring [WINDOW_LENGTH];

    logic [ACC_W-1:0]       acc_sum;
    logic                   s_fire;
    logic [PROD_W-1:0]      prod;
    logic [READING_W-1:0]   thr;
    logic                   hit;
    logic [COUNT_W-1:0]     le_total;
    logic [COUNT_W-1:0]     med_idx;
    logic                   rd_en;
    logic                   load_out;

    assign s_fire   = s_axis_tvalid && s_axis_tready;
    assign acc_sum  = acc_reg + ACC_W'(s_axis_tdata[SAMPLE_W-1:0]);
    assign prod     = PROD_W'(acc_reg) * PROD_W'(RECIP);
    // candidate with the current bit cleared and all lower bits set
    assign thr      = res_reg | (bit_mask_reg - READING_W'(1));
    assign hit      = rd_valid_reg && (rd_data_reg <= thr);
    assign le_total = le_cnt_reg + COUNT_W'(hit);
    assign med_idx  = fill_reg / COUNT_W'(MEDIAN_DIVISOR);
    assign rd_en    = (state_reg == ST_SCAN);
    assign load_out = (state_reg == ST_DONE) && (!m_valid_reg || m_axis_tready);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(M_TDATA_W - READING_W - COUNT_W){1'b0}}, held_reg, median_reg};

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_WRITE)
        begin
            ring[slot_reg] <= quo_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= ring[scan_idx_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            acc_reg      <= '0;
            grp_cnt_reg  <= '0;
            quo_reg      <= '0;
            slot_reg     <= '0;
            fill_reg     <= '0;
            scan_idx_reg <= '0;
            bit_mask_reg <= '0;
            res_reg      <= '0;
            le_cnt_reg   <= '0;
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            median_reg   <= '0;
            held_reg     <= '0;
        end
        else
        begin
            rd_valid_reg <= rd_en;
            if (load_out)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_valid_reg && m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_fire)
                    begin
                        acc_reg <= acc_sum;
                        if (grp_cnt_reg == GRP_W'(SAMPLES_PER_READING - 1))
                        begin
                            grp_cnt_reg <= '0;
                            state_reg   <= ST_DIV;
                        end
                        else
                        begin
                            grp_cnt_reg <= grp_cnt_reg + GRP_W'(1);
                        end
                    end
                end

                ST_DIV:
                begin
                    // sum / (SAMPLES_PER_READING << 3) by reciprocal multiply
                    quo_reg   <= prod[RECIP_SH +: READING_W];
                    state_reg <= ST_WRITE;
                end

                ST_WRITE:
                begin
                    acc_reg <= '0;
                    if (slot_reg == SLOT_W'(WINDOW_LENGTH - 1))
                    begin
                        slot_reg <= '0;
                    end
                    else
                    begin
                        slot_reg <= slot_reg + SLOT_W'(1);
                    end
                    if (fill_reg < WIN_CNT)
                    begin
                        fill_reg <= fill_reg + COUNT_W'(1);
                    end
                    scan_idx_reg <= '0;
                    bit_mask_reg <= MSB_MASK;
                    res_reg      <= '0;
                    le_cnt_reg   <= '0;
                    state_reg    <= ST_SCAN;
                end

                ST_SCAN:
                begin
                    le_cnt_reg <= le_total;
                    if (scan_idx_reg == SLOT_W'(fill_reg - COUNT_W'(1)))
                    begin
                        scan_idx_reg <= '0;
                        state_reg    <= ST_TALLY;
                    end
                    else
                    begin
                        scan_idx_reg <= scan_idx_reg + SLOT_W'(1);
                    end
                end

                ST_TALLY:
                begin
                    // more than med_idx readings at or below thr: this bit is 0
                    if (le_total <= med_idx)
                    begin
                        res_reg <= res_reg | bit_mask_reg;
                    end
                    le_cnt_reg   <= '0;
                    bit_mask_reg <= bit_mask_reg >> 1;
                    if (bit_mask_reg[0])
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        state_reg <= ST_SCAN;
                    end
                end

                ST_DONE:
                begin
                    if (load_out)
                    begin
                        median_reg <= res_reg;
                        held_reg   <= fill_reg;
                        state_reg  <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> (held_reg != '0) && (held_reg <= WIN_CNT))
        else $error("readings_held out of range");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        slot_reg <= SLOT_W'(WINDOW_LENGTH - 1))
        else $error("write slot past end of ring");

    a_tally_data: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TALLY) |-> rd_valid_reg)
        else $error("tally without the last ring read");

    a_group_close: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && (grp_cnt_reg == GRP_W'(SAMPLES_PER_READING - 1)))
            |=> (state_reg == ST_DIV))
        else $error("closing sample did not start division");

    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside of completion");
`endif

endmodule

@@ verif/averaged_sliding_median_filter_unit_tb.sv @@
module averaged_sliding_median_filter_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import avsmf_pkg::*;

    localparam int SPR          = SAMPLES_PER_READING_DEF;
    localparam int WIN          = WINDOW_LENGTH_DEF;
    localparam int RANDOM_ITEMS = 880;
    localparam int MAX_IDLE     = 13;
    localparam int HOLD_CYCLES  = 600;
    localparam int TAIL_CYCLES  = 160;
    localparam int STUCK_LIMIT  = 4000;
    localparam int SHOW_LIMIT   = 10;

    typedef struct packed {
        logic [COUNT_W-1:0]   held;
        logic [READING_W-1:0] median;
    } median_result_t;

    typedef struct {
        logic [SAMPLE_W-1:0]  sample;
        bit                   has_exp;
        logic [READING_W-1:0] median;
        logic [COUNT_W-1:0]   held;
    } stim_row_t;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;

    logic tx_idle_on  = 1'b1;
    logic rx_idle_on  = 1'b1;
    logic rx_hold     = 1'b0;
    logic pressure_go = 1'b0;

    // predictor state
    logic [ACC_W-1:0]     group_sum   = '0;
    logic [7:0]           group_count = '0;
    logic [READING_W-1:0] reading_window [WIN];
    logic [3:0]           next_slot   = '0;
    logic [3:0]           held_count  = '0;

    median_result_t pending_medians [$];
    stim_row_t      sent_rows [$];

    int mismatches    = 0;
    int samples_taken = 0;
    int medians_seen  = 0;
    int full_windows  = 0;
    int stall_run     = 0;
    int longest_stall = 0;
    int rx_wait_left  = 0;

    // two typed groups (all-max then all-min), then a mixed group checked by prediction
    stim_row_t directed_rows [24] = '{
        '{12'hFFF, 1'b0, 9'd0,   4'd0},
        '{12'hFFF, 1'b0, 9'd0,   4'd0},
        '{12'hFFF, 1'b0, 9'd0,   4'd0},
        '{12'hFFF, 1'b0, 9'd0,   4'd0},
        '{12'hFFF, 1'b0, 9'd0,   4'd0},
        '{12'hFFF, 1'b0, 9'd0,   4'd0},
        '{12'hFFF, 1'b0, 9'd0,   4'd0},
        '{12'hFFF, 1'b1, 9'd511, 4'd1},
        '{12'h000, 1'b0, 9'd0,   4'd0},
        '{12'h000, 1'b0, 9'd0,   4'd0},
        '{12'h000, 1'b0, 9'd0,   4'd0},
        '{12'h000, 1'b0, 9'd0,   4'd0},
        '{12'h000, 1'b0, 9'd0,   4'd0},
        '{12'h000, 1'b0, 9'd0,   4'd0},
        '{12'h000, 1'b0, 9'd0,   4'd0},
        '{12'h000, 1'b1, 9'd511, 4'd2},    // upper median of two
        '{12'h800, 1'b0, 9'd0,   4'd0},
        '{12'h001, 1'b0, 9'd0,   4'd0},
        '{12'hAAA, 1'b0, 9'd0,   4'd0},
        '{12'h555, 1'b0, 9'd0,   4'd0},
        '{12'hFFE, 1'b0, 9'd0,   4'd0},
        '{12'h7FF, 1'b0, 9'd0,   4'd0},
        '{12'h123, 1'b0, 9'd0,   4'd0},
        '{12'h000, 1'b0, 9'd0,   4'd0}
    };

    averaged_sliding_median_filter_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 clk = ~clk;

    // Adds one sample to the running group; returns 1 with the new median when it closes one.
    function automatic bit fold_sample(input logic [SAMPLE_W-1:0] sample,
                                       output median_result_t res);
        logic [READING_W-1:0] sorted [WIN];
        logic [READING_W-1:0] key;
        logic [ACC_W-1:0]     average;
        int                   n;
        int                   j;
        res       = '0;
        group_sum = group_sum + ACC_W'(sample);
        if (int'(group_count) + 1 < SPR)
        begin
            group_count = group_count + 8'd1;
            return 1'b0;
        end
        average                   = group_sum / ACC_W'(SPR);
        reading_window[next_slot] = READING_W'(average >> READING_SHIFT);
        group_sum                 = '0;
        group_count               = '0;
        next_slot                 = (int'(next_slot) + 1 >= WIN) ? 4'd0 : next_slot + 4'd1;
        if (int'(held_count) < WIN)
            held_count = held_count + 4'd1;
        n = int'(held_count);
        for (int i = 0; i < n; i++)
        begin
            key = reading_window[i];
            j   = i - 1;
            while (j >= 0 && sorted[j] > key)
            begin
                sorted[j + 1] = sorted[j];
                j--;
            end
            sorted[j + 1] = key;
        end
        res.median = sorted[n / MEDIAN_DIVISOR];
        res.held   = held_count;
        return 1'b1;
    endfunction

    function automatic void note_mismatch(input string what, input median_result_t want,
                                          input median_result_t got);
        mismatches++;
        if (mismatches <= SHOW_LIMIT)
            $display("[%0t] %s: expected median %0d held %0d, got median %0d held %0d",
                     $realtime, what, want.median, want.held, got.median, got.held);
    endfunction

    task automatic offer_sample(input logic [SAMPLE_W-1:0] sample);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_TDATA_W - SAMPLE_W){1'b0}}, sample};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // request monitor: prediction on the input side, comparison on the output side
    always @(posedge clk)
    begin : monitor
        stim_row_t      row;
        median_result_t predicted;
        median_result_t want;
        median_result_t got;
        if (rst_n)
        begin
            if (s_axis_tvalid && !s_axis_tready)
            begin
                stall_run++;
                if (stall_run > longest_stall)
                    longest_stall = stall_run;
            end
            else
                stall_run = 0;

            if (s_axis_tvalid && s_axis_tready)
            begin
                row = sent_rows.pop_front();
                samples_taken++;
                if (fold_sample(s_axis_tdata[SAMPLE_W-1:0], predicted) || row.has_exp)
                begin
                    if (row.has_exp)
                    begin
                        predicted.median = row.median;
                        predicted.held   = row.held;
                    end
                    pending_medians.push_back(predicted);
                end
            end

            if (m_axis_tvalid && m_axis_tready)
            begin
                got.median = m_axis_tdata[READING_W-1:0];
                got.held   = m_axis_tdata[READING_W +: COUNT_W];
                medians_seen++;
                if (pending_medians.size() == 0)
                    note_mismatch("unexpected median", '0, got);
                else
                begin
                    want = pending_medians.pop_front();
                    if (got.median !== want.median || got.held !== want.held)
                        note_mismatch("median mismatch", want, got);
                    if (int'(want.held) == WIN)
                        full_windows++;
                end
            end
        end
    end

    // output side idles per result; rx_hold forces a long hold-off
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                rx_wait_left = rx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
            else if (rx_wait_left > 0)
                rx_wait_left--;
            m_axis_tready <= (rx_wait_left == 0) && !rx_hold;
        end
    end

    initial
    begin
        wait (pressure_go);
        repeat (40) @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    initial
    begin : watchdog
        int stuck;
        stuck = 0;
        do
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stuck = 0;
            else
                stuck++;
        end
        while (stuck < STUCK_LIMIT);
        $display("Watchdog: no request moved for %0d cycles", STUCK_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin : stimulus
        stim_row_t row;
        int        level;
        int        pick;
        int        value;
        for (int i = 0; i < WIN; i++)
            reading_window[i] = '0;
        level = 2048;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[k])
        begin
            sent_rows.push_back(directed_rows[k]);
            offer_sample(directed_rows[k].sample);
        end

        // back-to-back input while the output is held off
        pressure_go <= 1'b1;
        tx_idle_on  <= 1'b0;
        rx_idle_on  <= 1'b0;

        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k % 64 == 63)
            begin
                tx_idle_on <= 1'($urandom_range(0, 1));
                rx_idle_on <= 1'($urandom_range(0, 1));
            end
            // keep a level across groups now and then so readings tie
            if (k % SPR == 0 && $urandom_range(0, 1) == 1)
                level = $urandom_range(0, 4095);
            pick = $urandom_range(0, 9);
            if (pick < 4)
                value = $urandom_range(0, 4095);
            else if (pick < 6)
                value = ($urandom_range(0, 1) == 1) ? 4095 : 0;
            else
            begin
                value = level + $urandom_range(0, 15) - 8;
                if (value < 0)
                    value = 0;
                if (value > 4095)
                    value = 4095;
            end
            row.sample  = SAMPLE_W'(value);
            row.has_exp = 1'b0;
            row.median  = '0;
            row.held    = '0;
            sent_rows.push_back(row);
            offer_sample(row.sample);
        end
        s_axis_tvalid <= 1'b0;

        while (pending_medians.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        while (pending_medians.size() != 0)
            note_mismatch("median never arrived", pending_medians.pop_front(), '0);

        $display("Covered %0d samples, %0d medians compared (%0d over a full window)",
                 samples_taken, medians_seen, full_windows);
        $display("Longest input stall %0d cycles, %0d mismatches", longest_stall, mismatches);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ averaged_sliding_median_filter_unit.f @@
hdl/avsmf_pkg.sv
hdl/averaged_sliding_median_filter_unit.sv
verif/averaged_sliding_median_filter_unit_tb.sv
